>>> design/gts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gts_pkg
// Shared types and constants of the trilinear grid sampler.
// ----------------------------------------------------------------------------
package gts_pkg;

  localparam int RES_W       = 6;
  localparam int FRAC_BITS   = 16;
  localparam int ADDR_FW     = 18;
  localparam int NUM_CORNERS = 8;
  localparam int CFG_IDX_W   = 2;

  localparam logic [FRAC_BITS:0] FRAC_ONE = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_RES_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RES_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RES_Z = 2'd2;

  localparam logic [RES_W-1:0] RES_RESET = 6'd32;

  typedef struct packed {
    logic                 lookup;
    logic                 ok;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [FRAC_BITS-1:0] fz;
  } meta_t;

endpackage

>>> design/gts_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gts_req_if / gts_rsp_if
// Request and result channels of the trilinear grid sampler.
// ----------------------------------------------------------------------------
interface gts_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [14:0]        voxel_index;
  logic [15:0]        voxel_value;
  logic signed [19:0] coord_x;
  logic signed [19:0] coord_y;
  logic signed [19:0] coord_z;

  modport source (
    output valid, req_type, voxel_index, voxel_value, coord_x, coord_y, coord_z,
    input  ready
  );
  modport sink (
    input  valid, req_type, voxel_index, voxel_value, coord_x, coord_y, coord_z,
    output ready
  );
endinterface

interface gts_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] density;
  logic        in_range;

  modport source (output valid, density, in_range, input ready);
  modport sink (input valid, density, in_range, output ready);
endinterface

>>> design/gts_addr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gts_addr
// Scales the position, splits cell and fraction, and forms the eight wrapped
// corner addresses (or the write address) over six pipeline stages.
// ----------------------------------------------------------------------------
module gts_addr #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15,
  parameter int VB    = 16
) (
  input  logic                         clk_i,
  input  logic [5:0]                   en_i,
  input  logic                         req_type_i,
  input  logic [14:0]                  voxel_index_i,
  input  logic [15:0]                  voxel_value_i,
  input  logic signed [19:0]           coord_x_i,
  input  logic signed [19:0]           coord_y_i,
  input  logic signed [19:0]           coord_z_i,
  input  logic [gts_pkg::RES_W-1:0]    res_x_i,
  input  logic [gts_pkg::RES_W-1:0]    res_y_i,
  input  logic [gts_pkg::RES_W-1:0]    res_z_i,
  input  logic [2*gts_pkg::RES_W-1:0]  slab_i,
  output logic [AW-1:0]                addr_o [gts_pkg::NUM_CORNERS],
  output logic [VB-1:0]                wdata_o,
  output gts_pkg::meta_t               meta_o
);

  localparam int FW    = gts_pkg::ADDR_FW;
  localparam int AFW   = (FW > AW) ? FW : AW;
  localparam int SHIFT = FW + AW;
  localparam int RW    = FW + 2;
  localparam int PW    = FW + RW;
  localparam int QW    = FW + AW + 1;
  localparam int NC    = gts_pkg::NUM_CORNERS;
  localparam int RS    = gts_pkg::RES_W;
  localparam int FB    = gts_pkg::FRAC_BITS;
  localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(DEPTH) - 1)
                               / longint'(DEPTH);
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
  localparam logic [QW-1:0] DEPTH_Q = QW'(DEPTH);

  typedef struct packed {
    logic          lookup;
    logic [14:0]   widx;
    logic [VB-1:0] wdata;
  } pass_t;

  logic signed [26:0] px_q, py_q, pz_q;
  pass_t              pass_q [6];
  logic [RS-1:0]      cx_q, cy_q, cz_q;
  logic               ok_q [1:5];
  logic [FB-1:0]      fx_q [1:5], fy_q [1:5], fz_q [1:5];
  logic [FW-1:0]      base_q;
  logic [FW-1:0]      a3_q [NC];
  logic [FW-1:0]      a4_q [NC];
  logic [FW-1:0]      q4_q [NC];
  logic [AW-1:0]      r5_q [NC];

  function automatic logic axis_ok(logic signed [26:0] p, logic [RS-1:0] res);
    return !p[26] && (({1'b0, p[25:16]} + 11'd1) < {5'd0, res});
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      px_q <= $signed(coord_x_i) * $signed({1'b0, res_x_i});
      py_q <= $signed(coord_y_i) * $signed({1'b0, res_y_i});
      pz_q <= $signed(coord_z_i) * $signed({1'b0, res_z_i});
      pass_q[0] <= '{lookup: req_type_i, widx: voxel_index_i, wdata: VB'(voxel_value_i)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      cx_q     <= px_q[16+RS-1:16];
      cy_q     <= py_q[16+RS-1:16];
      cz_q     <= pz_q[16+RS-1:16];
      fx_q[1]  <= px_q[FB-1:0];
      fy_q[1]  <= py_q[FB-1:0];
      fz_q[1]  <= pz_q[FB-1:0];
      ok_q[1]  <= axis_ok(px_q, res_x_i) && axis_ok(py_q, res_y_i) && axis_ok(pz_q, res_z_i);
      pass_q[1] <= pass_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      base_q <= FW'(cz_q) * FW'(slab_i) + FW'(cy_q) * FW'(res_x_i) + FW'(cx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      for (int i = 0; i < NC; i++) begin
        if (i == 0 && !pass_q[2].lookup) begin
          a3_q[i] <= FW'(pass_q[2].widx);
        end else begin
          a3_q[i] <= base_q + FW'(i % 2) + ((i % 4) >= 2 ? FW'(res_x_i) : '0)
                     + (i >= 4 ? FW'(slab_i) : '0);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      for (int i = 0; i < NC; i++) begin
        a4_q[i] <= a3_q[i];
        q4_q[i] <= FW'((PW'(a3_q[i]) * PW'(RECIP)) >> SHIFT);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      for (int i = 0; i < NC; i++) begin
        r5_q[i] <= AW'(AFW'(a4_q[i]) - AFW'(QW'(q4_q[i]) * DEPTH_Q));
      end
    end
  end

  for (genvar s = 2; s < 6; s++) begin : g_pass
    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        pass_q[s] <= pass_q[s-1];
        ok_q[s]   <= ok_q[s-1];
        fx_q[s]   <= fx_q[s-1];
        fy_q[s]   <= fy_q[s-1];
        fz_q[s]   <= fz_q[s-1];
      end
    end
  end

  assign addr_o  = r5_q;
  assign wdata_o = pass_q[5].wdata;
  assign meta_o  = '{lookup: pass_q[5].lookup, ok: ok_q[5], fx: fx_q[5], fy: fy_q[5],
                     fz: fz_q[5]};

endmodule

>>> design/gts_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gts_bank
// One copy of the voxel store with one write port and two registered reads.
// ----------------------------------------------------------------------------
module gts_bank #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15,
  parameter int VB    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [VB-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr0_i,
  input  logic [AW-1:0] raddr1_i,
  output logic [VB-1:0] rdata0_o,
  output logic [VB-1:0] rdata1_o
);

  logic [VB-1:0] mem [DEPTH];
  logic [VB-1:0] rdata0_q, rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_q <= mem[raddr0_i];
      rdata1_q <= mem[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

>>> design/gts_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gts_interp
// Three interpolation stages: along x, then y, then z, with the output
// register as the last stage.
// ----------------------------------------------------------------------------
module gts_interp #(
  parameter int VB = 16
) (
  input  logic           clk_i,
  input  logic [2:0]     en_i,
  input  logic [VB-1:0]  corner_i [gts_pkg::NUM_CORNERS],
  input  gts_pkg::meta_t meta_i,
  output logic [15:0]    density_o,
  output logic           in_range_o
);

  localparam int FB = gts_pkg::FRAC_BITS;
  localparam int SW = VB + FB + 2;

  logic [VB-1:0]  e_q [4];
  logic [VB-1:0]  g_q [2];
  gts_pkg::meta_t m7_q, m8_q;
  logic [15:0]    density_q;
  logic           in_range_q;

  function automatic logic [VB-1:0] lerp(logic [VB-1:0] a, logic [VB-1:0] b,
                                         logic [FB-1:0] f);
    logic [SW-1:0] s;
    s = SW'(a) * SW'(gts_pkg::FRAC_ONE - {1'b0, f}) + SW'(b) * SW'(f);
    return s[VB+FB-1:FB];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int j = 0; j < 4; j++) begin
        e_q[j] <= lerp(corner_i[2*j], corner_i[2*j+1], meta_i.fx);
      end
      m7_q <= meta_i;
    end
    if (en_i[1]) begin
      g_q[0] <= lerp(e_q[0], e_q[1], m7_q.fy);
      g_q[1] <= lerp(e_q[2], e_q[3], m7_q.fy);
      m8_q   <= m7_q;
    end
    if (en_i[2]) begin
      density_q  <= m8_q.ok ? 16'(lerp(g_q[0], g_q[1], m8_q.fz)) : '0;
      in_range_q <= m8_q.ok;
    end
  end

  assign density_o  = density_q;
  assign in_range_o = in_range_q;

endmodule

>>> design/grid_trilinear_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_trilinear_sampler
// 3D density grid with voxel writes and trilinear lookups.
//
//   channel | dir | payload
//   req     | in  | req_type, voxel_index, voxel_value, coord_x/y/z
//   rsp     | out | density, in_range (one per lookup, none per write)
//   cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i (res_x, res_y, res_z)
//
// Ten pipeline stages, the last of which holds the result; one item can be
// accepted every cycle unless the result side stalls a full pipeline.
// The voxel store is four copies with two read ports each, so the eight
// corners are read in the single memory stage.
// Stalls back up stage by stage and empty stages are filled; no clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module grid_trilinear_sampler #(
  parameter int DIM_MAX    = 32,
  parameter int VALUE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gts_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gts_pkg::RES_W-1:0]         cfg_data_i,
  gts_req_if.sink                           req,
  gts_rsp_if.source                         rsp
);

  localparam int DEPTH  = DIM_MAX * DIM_MAX * DIM_MAX;
  localparam int AW     = $clog2(DEPTH);
  localparam int NS     = 10;
  localparam int ST_MEM = 6;
  localparam int ST_X   = 7;
  localparam int NC     = gts_pkg::NUM_CORNERS;
  localparam int RS     = gts_pkg::RES_W;

  logic [RS-1:0]    res_x_q, res_y_q, res_z_q;
  logic [2*RS-1:0]  slab_q;
  logic [NS-1:0]    v_q;
  logic [NS-1:0]    en;
  logic [AW-1:0]    addr5 [NC];
  logic [VALUE_BITS-1:0] wdata5;
  logic [VALUE_BITS-1:0] corner [NC];
  gts_pkg::meta_t   meta5, meta6_q;
  logic             mem_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_x_q <= gts_pkg::RES_RESET;
      res_y_q <= gts_pkg::RES_RESET;
      res_z_q <= gts_pkg::RES_RESET;
      slab_q  <= 12'd1024;
    end else begin
      slab_q <= {{RS{1'b0}}, res_x_q} * {{RS{1'b0}}, res_y_q};
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          gts_pkg::REG_RES_X: res_x_q <= cfg_data_i;
          gts_pkg::REG_RES_Y: res_y_q <= cfg_data_i;
          gts_pkg::REG_RES_Z: res_z_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    en[NS-1] = !v_q[NS-1] || rsp.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= req.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == ST_X) ? (v_q[k-1] && meta6_q.lookup) : v_q[k-1];
        end
      end
    end
  end

  assign req.ready = en[0];

  gts_addr #(.DEPTH(DEPTH), .AW(AW), .VB(VALUE_BITS)) u_addr (
    .clk_i         (clk_i),
    .en_i          (en[5:0]),
    .req_type_i    (req.req_type),
    .voxel_index_i (req.voxel_index),
    .voxel_value_i (req.voxel_value),
    .coord_x_i     (req.coord_x),
    .coord_y_i     (req.coord_y),
    .coord_z_i     (req.coord_z),
    .res_x_i       (res_x_q),
    .res_y_i       (res_y_q),
    .res_z_i       (res_z_q),
    .slab_i        (slab_q),
    .addr_o        (addr5),
    .wdata_o       (wdata5),
    .meta_o        (meta5)
  );

  assign mem_we = en[ST_MEM] && v_q[ST_MEM-1] && !meta5.lookup;

  for (genvar b = 0; b < NC / 2; b++) begin : g_bank
    gts_bank #(.DEPTH(DEPTH), .AW(AW), .VB(VALUE_BITS)) u_bank (
      .clk_i    (clk_i),
      .we_i     (mem_we),
      .waddr_i  (addr5[0]),
      .wdata_i  (wdata5),
      .re_i     (en[ST_MEM]),
      .raddr0_i (addr5[2*b]),
      .raddr1_i (addr5[2*b+1]),
      .rdata0_o (corner[2*b]),
      .rdata1_o (corner[2*b+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_MEM]) begin
      meta6_q <= meta5;
    end
  end

  gts_interp #(.VB(VALUE_BITS)) u_interp (
    .clk_i      (clk_i),
    .en_i       (en[NS-1:ST_X]),
    .corner_i   (corner),
    .meta_i     (meta6_q),
    .density_o  (rsp.density),
    .in_range_o (rsp.in_range)
  );

  assign rsp.valid = v_q[NS-1];

`ifndef SYNTH
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.in_range |-> rsp.density == 16'd0)
    else $error("outside lookup gave nonzero density");

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req.ready |-> &v_q)
    else $error("input blocked while a stage is empty");

  a_write_in_mem_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> v_q[ST_MEM] && !meta6_q.lookup)
    else $error("store write not followed by its item in the memory stage");

  a_no_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en[ST_X] && v_q[ST_MEM] && !meta6_q.lookup |=> !v_q[ST_X])
    else $error("write item entered the interpolation stages");
`endif

endmodule

>>> tb/tb_grid_trilinear_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_trilinear_sampler
// Self-checking testbench of the trilinear grid sampler.
//
// A small grid model predicts every lookup. Before each in-range lookup the
// missing corner voxels are written, so no interior result reads an unwritten entry.
// The run steps through several grid resolutions, from 0 and 1 up to values
// whose addresses wrap. Both channels idle at random, and the result side
// also holds off for one long stretch.
// ----------------------------------------------------------------------------
module tb_grid_trilinear_sampler;

  localparam logic [gts_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int STORE_DEPTH = 32768;
  localparam int DRAIN_CYCLES = 24;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PER_PHASE = 190;
  localparam bit REQ_WRITE = 1'b0;
  localparam bit REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic [15:0] density;
    logic        in_range;
  } density_exp_t;

  class grid_model;
    logic [15:0] store [STORE_DEPTH];
    int unsigned res_x = 32, res_y = 32, res_z = 32;
    density_exp_t density_q[$];
    int errors = 0;
    int n_inside = 0, n_outside = 0, n_writes = 0;

    function automatic bit split_axis(logic signed [19:0] c, int unsigned r,
                                      output longint frac);
      longint p, cell_idx;
      p = longint'(c) * longint'(r);
      cell_idx = p >>> 16;
      frac = p & 64'hFFFF;
      return (cell_idx >= 0) && (cell_idx < longint'(r) - 1);
    endfunction

    function automatic bit corners(logic signed [19:0] x, y, z,
                                   output int unsigned addr[8],
                                   output longint fx, fy, fz);
      bit ok;
      longint row, slab, base, cx, cy, cz;
      ok = split_axis(x, res_x, fx);
      ok = split_axis(y, res_y, fy) && ok;
      ok = split_axis(z, res_z, fz) && ok;
      cx = (longint'(x) * res_x) >>> 16;
      cy = (longint'(y) * res_y) >>> 16;
      cz = (longint'(z) * res_z) >>> 16;
      row = res_x;
      slab = row * res_y;
      base = cz * slab + cy * row + cx;
      for (int k = 0; k < 8; k++) begin
        addr[k] = int'((base + (k & 1) + ((k >> 1) & 1) * row + ((k >> 2) & 1) * slab)
                       % STORE_DEPTH);
      end
      return ok;
    endfunction

    function automatic longint blend(longint a, b, w);
      return (a * (65536 - w) + b * w) >> 16;
    endfunction

    function void note_request(logic t, logic [14:0] idx, logic [15:0] val,
                               logic signed [19:0] x, y, z);
      int unsigned a[8];
      longint fx, fy, fz, e00, e01, e10, e11, g0, g1;
      density_exp_t e;
      if (t == REQ_WRITE) begin
        store[idx] = val;
        n_writes++;
      end else if (!corners(x, y, z, a, fx, fy, fz)) begin
        e.density = '0;
        e.in_range = 1'b0;
        density_q.push_back(e);
        n_outside++;
      end else begin
        e00 = blend(store[a[0]], store[a[1]], fx);
        e01 = blend(store[a[2]], store[a[3]], fx);
        e10 = blend(store[a[4]], store[a[5]], fx);
        e11 = blend(store[a[6]], store[a[7]], fx);
        g0 = blend(e00, e01, fy);
        g1 = blend(e10, e11, fy);
        e.density = 16'(blend(g0, g1, fz));
        e.in_range = 1'b1;
        density_q.push_back(e);
        n_inside++;
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [15:0] density, logic in_range);
      density_exp_t e;
      if (density_q.size() == 0) begin
        report($sformatf("unexpected result density=%h in_range=%b", density, in_range));
      end else begin
        e = density_q.pop_front();
        if (density !== e.density) begin
          report($sformatf("density %h, expected %h", density, e.density));
        end
        if (in_range !== e.in_range) begin
          report($sformatf("in_range %b, expected %b", in_range, e.in_range));
        end
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [gts_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [gts_pkg::RES_W-1:0] cfg_data_i;

  gts_req_if req_if ();
  gts_rsp_if rsp_if ();

  grid_trilinear_sampler u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_if),
    .rsp        (rsp_if)
  );

  grid_model model = new();
  bit planned [STORE_DEPTH];
  bit idle_en;
  bit hold_want, hold_seen;
  int hold_left;
  int stall_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_want != hold_seen) begin
      hold_seen <= hold_want;
      hold_left <= HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= !idle_en || ($urandom_range(0, 99) >= 25);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        model.note_request(req_if.req_type, req_if.voxel_index, req_if.voxel_value,
                           req_if.coord_x, req_if.coord_y, req_if.coord_z);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        model.check_result(rsp_if.density, rsp_if.in_range);
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we_i) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("timeout: no progress for %0d cycles", STALL_LIMIT);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  task send_item(logic t, logic [14:0] idx, logic [15:0] val, logic signed [19:0] x, y, z);
    if (idle_en && $urandom_range(0, 99) < 25) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.req_type <= t;
    req_if.voxel_index <= idx;
    req_if.voxel_value <= val;
    req_if.coord_x <= x;
    req_if.coord_y <= y;
    req_if.coord_z <= z;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task write_voxel(logic [14:0] idx, logic [15:0] val);
    planned[idx] = 1'b1;
    send_item(REQ_WRITE, idx, val, 20'($urandom), 20'($urandom), 20'($urandom));
  endtask

  task lookup(logic signed [19:0] x, y, z);
    int unsigned a[8];
    longint fx, fy, fz;
    if (model.corners(x, y, z, a, fx, fy, fz)) begin
      for (int k = 0; k < 8; k++) begin
        if (!planned[a[k]]) write_voxel(15'(a[k]), 16'($urandom));
      end
    end
    send_item(REQ_LOOKUP, 15'($urandom), 16'($urandom), x, y, z);
  endtask

  task drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (model.density_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task write_reg(logic [gts_pkg::CFG_IDX_W-1:0] idx, logic [gts_pkg::RES_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == gts_pkg::REG_RES_X) model.res_x = val;
    else if (idx == gts_pkg::REG_RES_Y) model.res_y = val;
    else if (idx == gts_pkg::REG_RES_Z) model.res_z = val;
  endtask

  function automatic logic signed [19:0] pick_coord(int unsigned r);
    int unsigned sel, top;
    sel = $urandom_range(0, 99);
    top = (r > 1) ? (65536 * (r - 1)) / r : 65535;
    if (sel < 65) return 20'($urandom_range(0, top));
    if (sel < 80) return 20'($urandom);
    if (sel < 90) return -20'($urandom_range(1, 70000));
    return 20'(int'(top) + int'($urandom_range(0, 4)) - 2);
  endfunction

  initial begin
    int unsigned grid [6][3] = '{'{32, 32, 32}, '{5, 7, 3}, '{2, 2, 2},
                                 '{1, 1, 1}, '{0, 9, 4}, '{40, 63, 17}};
    rst_ni = 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= gts_pkg::REG_RES_X;
    cfg_data_i <= '0;
    req_if.valid <= 1'b0;
    req_if.req_type <= REQ_WRITE;
    req_if.voxel_index <= '0;
    req_if.voxel_value <= '0;
    req_if.coord_x <= '0;
    req_if.coord_y <= '0;
    req_if.coord_z <= '0;
    idle_en = 1'b1;
    hold_want = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_voxel(15'd0, 16'h0000);
    write_voxel(15'd1, 16'hFFFF);
    write_voxel(15'd32767, 16'hFFFF);
    write_voxel(15'h5555, 16'h5555);
    write_voxel(15'h2AAA, 16'hAAAA);
    lookup(20'sd0, 20'sd0, 20'sd0);
    lookup(20'sd2047, 20'sd2047, 20'sd2047);
    lookup(20'sd63487, 20'sd63487, 20'sd63487);
    lookup(20'sd63488, 20'sd0, 20'sd0);
    lookup(20'sd0, -20'sd1, 20'sd0);
    lookup(20'sh7FFFF, 20'sd0, 20'sd0);
    lookup(20'sd0, 20'sd0, -20'sh80000);
    lookup(20'sd1024, 20'sd40000, 20'sd65535);
    lookup(20'sd31, 20'sd65000, 20'sd12345);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(gts_pkg::REG_RES_X, gts_pkg::RES_W'(grid[ph][0]));
      write_reg(gts_pkg::REG_RES_Y, gts_pkg::RES_W'(grid[ph][1]));
      write_reg(gts_pkg::REG_RES_Z, gts_pkg::RES_W'(grid[ph][2]));
      if (ph == 1) write_reg(REG_SPARE, 6'h3F);
      idle_en = (ph != 2);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (ph == 0 && n == 100) hold_want = !hold_want;
        if ($urandom_range(0, 99) < 25) begin
          write_voxel(15'($urandom), 16'($urandom));
        end else begin
          lookup(pick_coord(model.res_x), pick_coord(model.res_y), pick_coord(model.res_z));
        end
      end
      drain();
    end

    $display("covered %0d voxel writes, %0d interior lookups, %0d outside lookups",
             model.n_writes, model.n_inside, model.n_outside);
    $display("over six grid resolutions, from empty grids to wrapping addresses");
    if (model.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

>>> filelist.f
design/gts_pkg.sv
design/gts_if.sv
design/gts_addr.sv
design/gts_bank.sv
design/gts_interp.sv
design/grid_trilinear_sampler.sv
tb/tb_grid_trilinear_sampler.sv
